/* hw/rtl/miow_pkg.sv */
// ----------------------------------------------------------------------------
// miow_pkg
// Shared types and constants of the mono icon overlay writer.
// ----------------------------------------------------------------------------
package miow_pkg;

    localparam int ADDR_BITS = 25;
    localparam int COORD_W   = 13;
    localparam int FULL_W    = 27;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [7:0] MODE_COLOUR = 8'd1;
    localparam logic [7:0] MODE_WHITE  = 8'd2;

    localparam logic [7:0] COLOUR_Y = 8'd150;
    localparam logic [7:0] COLOUR_U = 8'd60;
    localparam logic [7:0] COLOUR_V = 8'd100;
    localparam logic [7:0] WHITE_Y  = 8'hff;
    localparam logic [7:0] WHITE_U  = 8'h00;

    typedef enum logic [2:0] {
        CFG_START_X     = 3'd0,
        CFG_START_Y     = 3'd1,
        CFG_ICON_SIZE   = 3'd2,
        CFG_COLOR_MODE  = 3'd3,
        CFG_LINE_PITCH  = 3'd4,
        CFG_CHROMA_BASE = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_LUMA = 2'd0,
        PH_U    = 2'd1,
        PH_V    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [7:0]  icon_size;
        logic [7:0]  color_mode;
        logic [12:0] line_pitch;
        logic [23:0] chroma_base;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_pix;

endpackage

/* hw/rtl/miow_front.sv */
// ----------------------------------------------------------------------------
// miow_front
// Walks each bitmap byte one pixel a cycle, stalling on a set pixel while the
// queue is full, tracks the icon position and queues the frame coordinates of every set pixel.
// ----------------------------------------------------------------------------
module miow_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  miow_pkg::t_cfg  i_cfg,
    input  logic            push,
    input  logic [7:0]      i_bitmap_byte,
    output logic            full,
    output logic            o_q_push,
    output miow_pkg::t_pix  o_q_data,
    input  logic            i_q_full
);
    import miow_pkg::*;

    logic       r_busy, n_busy;
    logic [7:0] r_bits, n_bits;
    logic [2:0] r_bcnt, n_bcnt;
    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;

    logic [8:0]  size;
    logic        outside;
    logic [7:0]  col_eff, row_eff;
    logic [8:0]  col_inc, row_inc;
    logic        row_end, icon_end;
    logic        step, finish;
    logic [8:0]  cols_left, rows_left;
    logic [17:0] rem;
    logic [2:0]  rem_sat;
    logic [6:0]  in_icon;

    always_comb begin
        size     = (i_cfg.icon_size == 8'd0) ? 9'd256 : {1'b0, i_cfg.icon_size};
        outside  = ({1'b0, r_col} >= size) || ({1'b0, r_row} >= size);
        col_eff  = outside ? 8'd0 : r_col;
        row_eff  = outside ? 8'd0 : r_row;
        col_inc  = {1'b0, col_eff} + 9'd1;
        row_inc  = {1'b0, row_eff} + 9'd1;
        row_end  = col_inc >= size;
        icon_end = row_end && (row_inc >= size);

        cols_left = size - {1'b0, col_eff} - 9'd1;
        rows_left = size - {1'b0, row_eff} - 9'd1;
        rem       = 18'(rows_left) * 18'(size) + 18'(cols_left);
        rem_sat   = (rem > 18'd7) ? 3'd7 : rem[2:0];
        for (int j = 0; j < 7; j++) begin
            in_icon[6-j] = 3'(j) < rem_sat;
        end

        step     = r_busy && (!r_bits[7] || !i_q_full);
        finish   = step && ((r_bcnt == 3'd7) || icon_end);
        full     = r_busy && !finish;

        o_q_push      = step && r_bits[7];
        o_q_data.x    = COORD_W'(i_cfg.start_x) + COORD_W'(col_eff);
        o_q_data.y    = COORD_W'(i_cfg.start_y) + COORD_W'(row_eff);
        o_q_data.last = !(|(r_bits[6:0] & in_icon));

        n_busy = r_busy;
        n_bits = r_bits;
        n_bcnt = r_bcnt;
        n_col  = r_col;
        n_row  = r_row;
        if (step) begin
            n_bits = {r_bits[6:0], 1'b0};
            n_bcnt = r_bcnt + 3'd1;
            n_col  = row_end ? 8'd0 : col_inc[7:0];
            n_row  = row_end ? (icon_end ? 8'd0 : row_inc[7:0]) : row_eff;
            if (finish) begin
                n_busy = 1'b0;
            end
        end
        if (push && !full) begin
            n_busy = 1'b1;
            n_bits = i_bitmap_byte;
            n_bcnt = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bcnt <= 3'd0;
            r_col  <= 8'd0;
            r_row  <= 8'd0;
        end else begin
            r_busy <= n_busy;
            r_bcnt <= n_bcnt;
            r_col  <= n_col;
            r_row  <= n_row;
        end
        r_bits <= n_bits;
    end

endmodule

/* hw/rtl/miow_queue.sv */
// ----------------------------------------------------------------------------
// miow_queue
// Short pixel queue between the front and the back.
// ----------------------------------------------------------------------------
module miow_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  miow_pkg::t_pix  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output miow_pkg::t_pix  o_data,
    output logic            o_empty
);
    import miow_pkg::*;

    t_pix              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push, do_pop;

    always_comb begin
        o_full  = r_count == (QPTR_W+1)'(QDEPTH);
        o_empty = r_count == '0;
        o_data  = r_mem[r_rd_ptr];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/miow_back.sv */
// ----------------------------------------------------------------------------
// miow_back
// Turns queued pixels into luma and chroma addresses and issues frame-buffer
// writes via an output register, one word a cycle while it is free or popped.
// ----------------------------------------------------------------------------
module miow_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  miow_pkg::t_cfg                 i_cfg,
    input  miow_pkg::t_pix                 i_q_data,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    output logic                           empty,
    input  logic                           pop,
    output logic [miow_pkg::ADDR_BITS-1:0] o_write_address,
    output logic [7:0]                     o_write_data,
    output logic                           o_last_write
);
    import miow_pkg::*;

    logic               r_p1_v;
    logic [COORD_W-1:0] r_p1_x;
    logic               r_p1_last;
    logic [25:0]        r_p1_ylum;
    logic [24:0]        r_p1_ychr;

    logic              r_p2_v;
    logic [FULL_W-1:0] r_p2_luma;
    logic [FULL_W-1:0] r_p2_uaddr;
    logic              r_p2_last;
    logic [7:0]        r_p2_mode;
    logic [1:0]        r_p2_nw;
    t_phase            r_p2_ph;

    logic                 r_o_v;
    logic [ADDR_BITS-1:0] r_o_addr;
    logic [7:0]           r_o_data;
    logic                 r_o_last;

    logic              emit_go, word_last, p2_done, p1_adv, p1_load;
    logic [1:0]        nw;
    logic [FULL_W-1:0] emit_addr;
    logic [7:0]        emit_data;
    t_phase            next_ph;

    always_comb begin
        emit_go   = r_p2_v && (!r_o_v || pop);
        word_last = {1'b0, r_p2_ph} == ({1'b0, r_p2_nw} - 3'd1);
        p2_done   = emit_go && word_last;
        p1_adv    = r_p1_v && (!r_p2_v || p2_done);
        p1_load   = !i_q_empty && (!r_p1_v || p1_adv);
        o_q_pop   = p1_load;
        empty     = !r_o_v;

        case (i_cfg.color_mode)
            MODE_COLOUR: nw = 2'd3;
            MODE_WHITE:  nw = 2'd2;
            default:     nw = 2'd1;
        endcase

        case (r_p2_ph)
            PH_LUMA: begin
                emit_addr = r_p2_luma;
                case (r_p2_mode)
                    MODE_COLOUR: emit_data = COLOUR_Y;
                    MODE_WHITE:  emit_data = WHITE_Y;
                    default:     emit_data = r_p2_mode;
                endcase
                next_ph = PH_U;
            end
            PH_U: begin
                emit_addr = r_p2_uaddr;
                emit_data = (r_p2_mode == MODE_COLOUR) ? COLOUR_U : WHITE_U;
                next_ph   = PH_V;
            end
            PH_V: begin
                emit_addr = r_p2_uaddr + FULL_W'(1);
                emit_data = COLOUR_V;
                next_ph   = PH_LUMA;
            end
            default: begin
                emit_addr = r_p2_luma;
                emit_data = r_p2_mode;
                next_ph   = PH_LUMA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p2_ph <= PH_LUMA;
            r_o_v   <= 1'b0;
        end else begin
            if (p1_load) begin
                r_p1_v <= 1'b1;
            end else if (p1_adv) begin
                r_p1_v <= 1'b0;
            end
            if (p1_adv) begin
                r_p2_v  <= 1'b1;
                r_p2_ph <= PH_LUMA;
            end else if (p2_done) begin
                r_p2_v  <= 1'b0;
                r_p2_ph <= PH_LUMA;
            end else if (emit_go) begin
                r_p2_ph <= next_ph;
            end
            if (emit_go) begin
                r_o_v <= 1'b1;
            end else if (pop) begin
                r_o_v <= 1'b0;
            end
        end
        if (p1_load) begin
            r_p1_x    <= i_q_data.x;
            r_p1_last <= i_q_data.last;
            r_p1_ylum <= 26'(i_q_data.y) * 26'(i_cfg.line_pitch);
            r_p1_ychr <= 25'(i_q_data.y[COORD_W-1:1]) * 25'(i_cfg.line_pitch);
        end
        if (p1_adv) begin
            r_p2_luma  <= FULL_W'(r_p1_x) + FULL_W'(r_p1_ylum);
            r_p2_uaddr <= FULL_W'(i_cfg.chroma_base) + FULL_W'(r_p1_ychr)
                        + FULL_W'({r_p1_x[COORD_W-1:1], 1'b0});
            r_p2_last  <= r_p1_last;
            r_p2_mode  <= i_cfg.color_mode;
            r_p2_nw    <= nw;
        end
        if (emit_go) begin
            r_o_addr <= ADDR_BITS'(emit_addr);
            r_o_data <= emit_data;
            r_o_last <= r_p2_last && word_last;
        end
    end

    assign o_write_address = r_o_addr;
    assign o_write_data    = r_o_data;
    assign o_last_write    = r_o_last;

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> ({1'b0, r_p2_ph} < {1'b0, r_p2_nw}))
        else $error("write phase beyond word count");

    a_p2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p2_v && !p2_done) |=> (r_p2_v && $stable(r_p2_luma) && $stable(r_p2_uaddr)))
        else $error("address stage lost before its last word");

    a_p1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_v && !p1_adv) |=> (r_p1_v && $stable(r_p1_ylum)))
        else $error("product stage dropped while stalled");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !pop) |=> (r_o_v && $stable(r_o_addr) && $stable(r_o_data)))
        else $error("output word changed while waiting");

endmodule

/* hw/rtl/mono_icon_overlay_writer.sv */
// ----------------------------------------------------------------------------
// mono_icon_overlay_writer
// 1-bit-per-pixel icon blitter into an NV12 frame buffer.
// ----------------------------------------------------------------------------
// Throughput: the front walks one pixel a cycle, stalling on a set pixel while
// the queue is full, and stops early at the icon end; the back issues one write
// a cycle while the output is free or popped; colour mode needs up to 24 writes a byte.
// Reset: config registers to their defaults, icon position to the origin, queues empty.
// ----------------------------------------------------------------------------
module mono_icon_overlay_writer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [2:0]                     i_cfg_index,
    input  logic [23:0]                    i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_bitmap_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [miow_pkg::ADDR_BITS-1:0] o_write_address,
    output logic [7:0]                     o_write_data,
    output logic                           o_last_write
);
    import miow_pkg::*;

    t_cfg r_cfg;
    t_pix fq_data, qb_data;
    logic fq_push, fq_full, qb_pop, qb_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x     <= 12'd0;
            r_cfg.start_y     <= 12'd0;
            r_cfg.icon_size   <= 8'd24;
            r_cfg.color_mode  <= 8'd2;
            r_cfg.line_pitch  <= 13'd720;
            r_cfg.chroma_base <= 24'd414720;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_X:     r_cfg.start_x     <= i_cfg_data[11:0];
                CFG_START_Y:     r_cfg.start_y     <= i_cfg_data[11:0];
                CFG_ICON_SIZE:   r_cfg.icon_size   <= i_cfg_data[7:0];
                CFG_COLOR_MODE:  r_cfg.color_mode  <= i_cfg_data[7:0];
                CFG_LINE_PITCH:  r_cfg.line_pitch  <= i_cfg_data[12:0];
                CFG_CHROMA_BASE: r_cfg.chroma_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    miow_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .push          (push),
        .i_bitmap_byte (i_bitmap_byte),
        .full          (full),
        .o_q_push      (fq_push),
        .o_q_data      (fq_data),
        .i_q_full      (fq_full)
    );

    miow_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_data),
        .o_full  (fq_full),
        .i_pop   (qb_pop),
        .o_data  (qb_data),
        .o_empty (qb_empty)
    );

    miow_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_data        (qb_data),
        .i_q_empty       (qb_empty),
        .o_q_pop         (qb_pop),
        .empty           (empty),
        .pop             (pop),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_last_write    (o_last_write)
    );

endmodule
